FILE: design/fifo_queue_extract_min_macros.svh
// ----------------------------------------------------------------------------
// fifo_queue_extract_min_macros.svh
// Assertion macros shared by the queue block.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_EXTRACT_MIN_MACROS_SVH
`define FIFO_QUEUE_EXTRACT_MIN_MACROS_SVH

// same-cycle implication, disabled in reset
`define FQEM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define FQEM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/fqem_pkg.sv
// ----------------------------------------------------------------------------
// fqem_pkg
// Types and constants for the queue with extract-minimum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fqem_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int DATA_W          = 32;
	localparam int REQ_W           = 2;
	localparam int STAT_W          = 2;
	localparam int COUNT_OUT_W     = 5;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_EXTRACT = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_SHIFT_INIT,
		ST_SHIFT,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // latch request beat
		logic push_wr;     // write pushed value at rear
		logic scan_start;  // clear pointer for scan
		logic scan_rd;     // read entry at pointer, advance
		logic shift_init;  // pointer to entry after the minimum
		logic shift_rd;    // read entry at pointer, write it one lower
		logic finish;      // update count, load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_push;
		logic is_remove;
		logic full;
		logic empty;
		logic scan_last;
		logic shift_more;
		logic out_busy;
	} sts_t;

endpackage

FILE: design/fqem_ram.sv
// ----------------------------------------------------------------------------
// fqem_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fqem_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: design/fqem_ctrl.sv
// ----------------------------------------------------------------------------
// fqem_ctrl
// Sequencer for push, pop and extract-minimum requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fqem_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fqem_pkg::sts_t sts,
	output fqem_pkg::cmd_t cmd
);

	fqem_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqem_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fqem_pkg::ST_IDLE: begin
				if (in_valid) state_d = fqem_pkg::ST_EXEC;
			end
			fqem_pkg::ST_EXEC: begin
				if (sts.is_remove && !sts.empty) state_d = fqem_pkg::ST_SCAN;
				else                             state_d = fqem_pkg::ST_DONE;
			end
			fqem_pkg::ST_SCAN: begin
				if (sts.scan_last) state_d = fqem_pkg::ST_SCAN_WAIT;
			end
			fqem_pkg::ST_SCAN_WAIT:  state_d = fqem_pkg::ST_SHIFT_INIT;
			fqem_pkg::ST_SHIFT_INIT: state_d = fqem_pkg::ST_SHIFT;
			fqem_pkg::ST_SHIFT: begin
				if (!sts.shift_more) state_d = fqem_pkg::ST_DONE;
			end
			fqem_pkg::ST_DONE: begin
				if (!sts.out_busy) state_d = fqem_pkg::ST_IDLE;
			end
			default: state_d = fqem_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			fqem_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			fqem_pkg::ST_EXEC: begin
				cmd.push_wr    = sts.is_push && !sts.full;
				cmd.scan_start = sts.is_remove && !sts.empty;
			end
			fqem_pkg::ST_SCAN:       cmd.scan_rd = 1'b1;
			fqem_pkg::ST_SCAN_WAIT:  cmd = '0;
			fqem_pkg::ST_SHIFT_INIT: cmd.shift_init = 1'b1;
			fqem_pkg::ST_SHIFT:      cmd.shift_rd = sts.shift_more;
			fqem_pkg::ST_DONE:       cmd.finish = !sts.out_busy;
			default:                 cmd = '0;
		endcase
	end

endmodule

FILE: design/fqem_dpath.sv
// ----------------------------------------------------------------------------
// fqem_dpath
// Entry store, count, minimum scan, gap compaction and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fqem_dpath #(
	parameter int QUEUE_DEPTH = fqem_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fqem_pkg::cmd_t                    cmd,
	output fqem_pkg::sts_t                    sts,
	input  logic [fqem_pkg::REQ_W-1:0]        in_req,
	input  logic [fqem_pkg::DATA_W-1:0]       in_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fqem_pkg::DATA_W-1:0]       out_value,
	output logic [fqem_pkg::STAT_W-1:0]       out_status,
	output logic [fqem_pkg::COUNT_OUT_W-1:0]  out_count
);

	localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int EXT_W = CW + fqem_pkg::COUNT_OUT_W;

	logic [fqem_pkg::REQ_W-1:0]  req_q;
	logic [fqem_pkg::DATA_W-1:0] data_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               ptr_q;
	logic [AW-1:0]               best_idx_q;
	logic [fqem_pkg::DATA_W-1:0] best_val_q;
	logic                        scan_s1;
	logic [AW-1:0]               scan_idx_s1;
	logic                        wr_pend_s1;
	logic [AW-1:0]               wr_addr_s1;
	logic                        out_valid_q;

	logic                        ram_wr_en;
	logic [AW-1:0]               ram_wr_addr;
	logic [fqem_pkg::DATA_W-1:0] ram_wr_data;
	logic                        ram_rd_en;
	logic [fqem_pkg::DATA_W-1:0] ram_rd_data;

	logic                        is_push, is_remove, full, empty;
	logic [CW-1:0]               count_d;
	logic [EXT_W-1:0]            count_ext;
	logic [fqem_pkg::STAT_W-1:0] status_d;
	logic [CW-1:0]               scan_end;

	assign is_push   = (req_q == fqem_pkg::REQ_PUSH);
	assign is_remove = (req_q == fqem_pkg::REQ_POP) || (req_q == fqem_pkg::REQ_EXTRACT);
	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	// pop looks at the front only, extract at every entry
	assign scan_end  = (req_q == fqem_pkg::REQ_EXTRACT) ? (count_q - CW'(1)) : '0;

	assign sts.is_push    = is_push;
	assign sts.is_remove  = is_remove;
	assign sts.full       = full;
	assign sts.empty      = empty;
	assign sts.scan_last  = (ptr_q == scan_end);
	assign sts.shift_more = (ptr_q < count_q);
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign ram_rd_en   = cmd.scan_rd || cmd.shift_rd;
	assign ram_wr_en   = cmd.push_wr || wr_pend_s1;
	assign ram_wr_addr = cmd.push_wr ? count_q[AW-1:0] : wr_addr_s1;
	assign ram_wr_data = cmd.push_wr ? data_q : ram_rd_data;

	fqem_ram #(
		.WIDTH (fqem_pkg::DATA_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ptr_q[AW-1:0]),
		.rd_data (ram_rd_data)
	);

	// result of the request in flight
	always_comb begin
		count_d  = count_q;
		status_d = fqem_pkg::STAT_OK;
		if (is_push) begin
			if (full) status_d = fqem_pkg::STAT_FULL;
			else      count_d  = count_q + CW'(1);
		end else if (is_remove) begin
			if (empty) status_d = fqem_pkg::STAT_EMPTY;
			else       count_d  = count_q - CW'(1);
		end
	end

	assign count_ext = EXT_W'(count_d);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_s1     <= 1'b0;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			scan_s1    <= cmd.scan_rd;
			wr_pend_s1 <= cmd.shift_rd;
			if (cmd.finish) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= in_req;
			data_q <= in_value;
		end
		if (cmd.scan_start) begin
			ptr_q <= '0;
		end else if (cmd.shift_init) begin
			ptr_q <= CW'(best_idx_q) + CW'(1);
		end else if (cmd.scan_rd || cmd.shift_rd) begin
			ptr_q <= ptr_q + CW'(1);
		end
		scan_idx_s1 <= ptr_q[AW-1:0];
		wr_addr_s1  <= AW'(ptr_q - CW'(1));
		// strict compare keeps the entry nearest the front on ties
		if (scan_s1) begin
			if ((scan_idx_s1 == '0) || ($signed(ram_rd_data) < $signed(best_val_q))) begin
				best_val_q <= ram_rd_data;
				best_idx_q <= scan_idx_s1;
			end
		end
		if (cmd.finish) begin
			out_value  <= (is_remove && !empty) ? best_val_q : '0;
			out_status <= status_d;
			out_count  <= count_ext[fqem_pkg::COUNT_OUT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: design/fifo_queue_extract_min.sv
// ----------------------------------------------------------------------------
// fifo_queue_extract_min
// Bounded arrival-order queue of signed 32-bit values with push, pop and
// extract-minimum; one result beat per request beat.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                                 | tuser
//  ---------+-----+---------------------------------------+--------------------
//  s_axis   | in  | [31:0] data_value                     | [1:0] req_type
//  m_axis   | out | [31:0] removed_value, [36:32] count   | [1:0] status
//
//  Steps, accept included, up to the result load: push, failed removal or
//  unused code 3 go accept, execute, load; pop and extract add a scan (pop
//  reads the front only, extract every entry), a wait, a shift setup and the
//  gap close: one RAM read per cycle for the scan, then one move per cycle to
//  close the gap. Next beat taken in the cycle after the result load.
//  Reset: arst_n clears the count, the sequencer and the result valid.
//  Stalls: a waiting result does not block the input; only the next one waits.
`timescale 1ns / 1ps
`include "fifo_queue_extract_min_macros.svh"

module fifo_queue_extract_min #(
	parameter int QUEUE_DEPTH = fqem_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] data_value
	input  logic [7:0]  s_tuser,   // [1:0] req_type, [7:2] zero
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] entry_count, [39:37] zero
	output logic [7:0]  m_tuser    // [1:0] status, [7:2] zero
);

	fqem_pkg::cmd_t cmd;
	fqem_pkg::sts_t sts;

	logic [fqem_pkg::DATA_W-1:0]      out_value;
	logic [fqem_pkg::STAT_W-1:0]      out_status;
	logic [fqem_pkg::COUNT_OUT_W-1:0] out_count;
	logic                             full_beat;

	// sequencer: one request at a time
	fqem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, scan and compaction, result register
	fqem_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_req     (s_tuser[fqem_pkg::REQ_W-1:0]),
		.in_value   (s_tdata[fqem_pkg::DATA_W-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (out_value),
		.out_status (out_status),
		.out_count  (out_count)
	);

	assign m_tdata = {3'b000, out_count, out_value};
	assign m_tuser = {6'b000000, out_status};

	assign full_beat = m_tvalid && (out_status == fqem_pkg::STAT_FULL);

	// one request in flight: accept closes the input until the result is loaded
	`FQEM_ASSERT_NEXT(a_single_req, s_tvalid && s_tready, !s_tready, "second beat in flight")
	// finishing a request always presents a result beat
	`FQEM_ASSERT_NEXT(a_finish_valid, cmd.finish, m_tvalid, "finish without result beat")
	// a refused push removes nothing
	`FQEM_ASSERT_NOW(a_full_zero, full_beat, out_value == '0, "full status with nonzero value")

endmodule

FILE: test/fifo_queue_extract_min_test.sv
// ----------------------------------------------------------------------------
// fifo_queue_extract_min_test
// Self-checking bench for the queue with extract-minimum. A behavioral copy
// of the queue predicts the result of every accepted request beat; each
// result beat is checked against the oldest prediction. Directed beats
// cover empty and full queues, value extremes and tied minima. Random
// traffic then runs in fill, drain and balanced phases, with gaps and
// back-pressure on both channels, then again with neither.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_queue_extract_min_test;

	localparam logic [fqem_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int DEPTH        = fqem_pkg::QUEUE_DEPTH_DEF;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 900;
	localparam int BURST_ITEMS  = 250;
	localparam int MAX_PRINTS   = 100;

	typedef struct packed {
		logic signed [fqem_pkg::DATA_W-1:0] removed_value;
		logic [fqem_pkg::STAT_W-1:0]        status;
		logic [fqem_pkg::COUNT_OUT_W-1:0]   entry_count;
	} queue_result_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [7:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [7:0]  m_tuser;

	// behavioral copy of the queue, front at index 0
	logic signed [fqem_pkg::DATA_W-1:0] held_entries[$];
	queue_result_t                      pending_results[$];

	int error_count   = 0;
	int quiet_cycles  = 0;
	bit traffic_gaps  = 1'b1;

	fifo_queue_extract_min #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (error_count < MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $realtime, what);
		error_count++;
	endtask

	// apply one accepted request to the queue copy and log its result
	task automatic predict_result(input logic [fqem_pkg::REQ_W-1:0] req,
	                              input logic [fqem_pkg::DATA_W-1:0] value);
		queue_result_t r;
		int            min_pos;
		r = '0;
		case (req) inside
			fqem_pkg::REQ_PUSH: begin
				if (held_entries.size() >= DEPTH)
					r.status = fqem_pkg::STAT_FULL;
				else
					held_entries.push_back(value);
			end
			fqem_pkg::REQ_POP, fqem_pkg::REQ_EXTRACT: begin
				if (held_entries.size() == 0) begin
					r.status = fqem_pkg::STAT_EMPTY;
				end else if (req == fqem_pkg::REQ_POP) begin
					r.removed_value = held_entries.pop_front();
				end else begin
					// strict compare keeps the earliest of tied minima
					min_pos = 0;
					for (int i = 1; i < held_entries.size(); i++)
						if (held_entries[i] < held_entries[min_pos])
							min_pos = i;
					r.removed_value = held_entries[min_pos];
					held_entries.delete(min_pos);
				end
			end
			default: ;
		endcase
		r.entry_count = fqem_pkg::COUNT_OUT_W'(held_entries.size());
		pending_results.push_back(r);
	endtask

	// one request beat; tvalid stays high after the handshake so that the
	// next beat can follow without a bubble
	task automatic send_request(input logic [fqem_pkg::REQ_W-1:0] req,
	                            input logic [fqem_pkg::DATA_W-1:0] value);
		if (traffic_gaps) begin
			while ($urandom_range(99) < 18) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= {6'b0, req};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_result(req, value);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [fqem_pkg::DATA_W-1:0] random_value();
		int near_zero;
		near_zero = int'($urandom_range(8)) - 4;
		case ($urandom_range(9)) inside
			[0:3]:   return $urandom;
			[4:6]:   return fqem_pkg::DATA_W'(near_zero);   // small range forces ties
			7:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			8:       return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
			                                  : 32'h7fff_ffff - $urandom_range(3);
			default: return 32'h1 << $urandom_range(31);
		endcase
	endfunction

	// removals and the unused code on an empty queue
	task automatic test_empty_queue();
		send_request(fqem_pkg::REQ_POP, 32'hffff_ffff);
		send_request(fqem_pkg::REQ_EXTRACT, 32'h1234_5678);
		send_request(REQ_UNUSED, 32'h8000_0000);
		wait_for_results();
	endtask

	// fill with extremes and a doubled minimum, push past full, then remove
	task automatic test_full_queue_and_ties();
		logic [fqem_pkg::DATA_W-1:0] fill_values[DEPTH] = '{
			32'd5,         32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
			32'hffff_ffff, 32'h8000_0000, 32'h0000_0001, 32'haaaa_aaaa,
			32'h5555_5555, 32'h7fff_fffe, 32'h8000_0001, 32'hffff_fffe,
			32'd3,         32'h0001_0000, 32'hdead_beef, 32'h0fff_ffff
		};
		foreach (fill_values[i])
			send_request(fqem_pkg::REQ_PUSH, fill_values[i]);
		send_request(fqem_pkg::REQ_PUSH, 32'h1111_1111);
		send_request(REQ_UNUSED, 32'h7fff_ffff);
		// tied minimum: earliest copy goes first, order of the rest shows it
		send_request(fqem_pkg::REQ_EXTRACT, 32'h0);
		send_request(fqem_pkg::REQ_EXTRACT, 32'h0);
		send_request(fqem_pkg::REQ_POP, 32'h0);
		wait_for_results();
	endtask

	// phased random traffic: fill-heavy, drain-heavy (selection sort) and
	// balanced runs; the unused code is sprinkled in and not counted
	task automatic run_random_requests(input int item_total);
		int                          sent;
		int                          phase_left;
		int                          mode;
		int                          pick;
		logic [fqem_pkg::REQ_W-1:0]  req;
		sent       = 0;
		phase_left = 0;
		mode       = 0;
		while (sent < item_total) begin
			if (phase_left == 0) begin
				mode       = $urandom_range(2);
				phase_left = $urandom_range(40, 8);
			end
			pick = $urandom_range(99);
			if (pick < 3)
				req = REQ_UNUSED;
			else if (mode == 0)
				req = (pick < 75) ? fqem_pkg::REQ_PUSH :
				      ((pick < 88) ? fqem_pkg::REQ_EXTRACT : fqem_pkg::REQ_POP);
			else if (mode == 1)
				req = (pick < 30) ? fqem_pkg::REQ_PUSH :
				      ((pick < 75) ? fqem_pkg::REQ_EXTRACT : fqem_pkg::REQ_POP);
			else
				req = (pick < 52) ? fqem_pkg::REQ_PUSH :
				      ((pick < 80) ? fqem_pkg::REQ_EXTRACT : fqem_pkg::REQ_POP);
			send_request(req, random_value());
			phase_left--;
			if (req != REQ_UNUSED)
				sent++;
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		traffic_gaps = 1'b1;
		run_random_requests(RANDOM_ITEMS);
	endtask

	// no gaps and no back-pressure at all
	task automatic test_back_to_back();
		traffic_gaps = 1'b0;
		run_random_requests(BURST_ITEMS);
		traffic_gaps = 1'b1;
	endtask

	// result checker; m_tready is re-drawn every cycle
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected beat: value %0d status %0d count %0d",
					$signed(m_tdata[31:0]), m_tuser[1:0], m_tdata[36:32]));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[31:0] !== want.removed_value)
					report_mismatch($sformatf("removed_value %0d, expected %0d",
						$signed(m_tdata[31:0]), want.removed_value));
				if (m_tuser[1:0] !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						m_tuser[1:0], want.status));
				if (m_tdata[36:32] !== want.entry_count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						m_tdata[36:32], want.entry_count));
			end
		end
		m_tready <= !traffic_gaps || ($urandom_range(99) >= 18);
	end

	// watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_full_queue_and_ties();
		test_random_traffic();
		test_back_to_back();
		// let any stray beat show up before the verdict
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
